// File: hdl/owtr_pkg.sv
`timescale 1ns / 1ps

package owtr_pkg;

    // Configuration port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_SAMPLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOVERY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE    = 3'd6;

    // Register values after reset
    localparam logic [9:0] RST_RESET_LOW       = 10'd503;
    localparam logic [7:0] RST_PRESENCE_SAMPLE = 8'd70;
    localparam logic [9:0] RST_RESET_RECOVERY  = 10'd430;
    localparam logic [7:0] RST_SLOT            = 8'd63;
    localparam logic [3:0] RST_WRITE_LOW       = 4'd2;
    localparam logic [3:0] RST_READ_LOW        = 4'd1;
    localparam logic [3:0] RST_READ_SAMPLE     = 4'd1;

    // Bus commands
    localparam logic [7:0] CMD_SKIP_ROM       = 8'hCC;
    localparam logic [7:0] CMD_CONVERT        = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH   = 8'hBE;

    // Operation slots of the read sequence
    localparam logic [2:0] OP_RESET_FIRST  = 3'd0;
    localparam logic [2:0] OP_SKIP_FIRST   = 3'd1;
    localparam logic [2:0] OP_CONVERT      = 3'd2;
    localparam logic [2:0] OP_RESET_SECOND = 3'd3;
    localparam logic [2:0] OP_SKIP_SECOND  = 3'd4;
    localparam logic [2:0] OP_READ_CMD     = 3'd5;
    localparam logic [2:0] OP_READ_LSB     = 3'd6;
    localparam logic [2:0] OP_READ_MSB     = 3'd7;

    typedef struct packed {
        logic start_req;
        logic line_level;
    } t_in_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [6:0] temperature;
    } t_out_item;

    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [7:0] presence_sample_ticks;
        logic [9:0] reset_recovery_ticks;
        logic [7:0] slot_ticks;
        logic [3:0] write_low_ticks;
        logic [3:0] read_low_ticks;
        logic [3:0] read_sample_ticks;
    } t_cfg;

endpackage

// File: hdl/onewire_temperature_read_master_top.sv
`timescale 1ns / 1ps

// One-wire temperature read master.
// Input channel: one item per bus tick (i_in_valid / o_in_stall), carrying a
// start request and the sampled bus level. A start seen while idle runs the
// full sequence: reset with presence check (repeated until a device answers),
// skip ROM + convert, second reset, skip ROM + read scratchpad, two byte reads.
// Output channel: one item per input item (o_out_valid / i_out_stall) with the
// drive level for the next tick, busy, a one-item done pulse and the latest
// whole-degree temperature.
// Result: a result appears in the output register in the cycle after its tick
// item is taken. Throughput: one item per cycle while o_in_stall is low; the
// sequencer state and the output register both update in the accepting cycle.
// Stall: while the output register holds an untaken item and i_out_stall is
// high, o_in_stall is raised and the sequencer holds.
// Configuration: seven timing registers on the write channel, taken every
// cycle (o_cfg_ready is always high); write only while idle.
// Reset: timing registers return to their defaults, the sequencer goes idle,
// the temperature clears and the output register empties.
module onewire_temperature_read_master_top
    import owtr_pkg::*;
#(
    parameter int COUNT_WIDTH = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_out_item result;
    logic      accept;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;

    owtr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    owtr_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept),
        .i_item   (i_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Load a result per accepted item, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The finishing item reports idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.done_res) |-> !o_out_item.busy_res)
        else $error("done item still reports busy");

    // The bus is only pulled low during a sequence
    a_drive_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.drive_low) |-> o_out_item.busy_res)
        else $error("bus driven low while idle");

    // Input backpressure only comes from a held result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

endmodule

// File: hdl/owtr_cfg_regs.sv
`timescale 1ns / 1ps

module owtr_cfg_regs
    import owtr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Load reset timings, then take writes by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks       <= RST_RESET_LOW;
            r_cfg.presence_sample_ticks <= RST_PRESENCE_SAMPLE;
            r_cfg.reset_recovery_ticks  <= RST_RESET_RECOVERY;
            r_cfg.slot_ticks            <= RST_SLOT;
            r_cfg.write_low_ticks       <= RST_WRITE_LOW;
            r_cfg.read_low_ticks        <= RST_READ_LOW;
            r_cfg.read_sample_ticks     <= RST_READ_SAMPLE;
        end else if (i_wr_en) begin
            case (i_index)
                CFG_RESET_LOW:       r_cfg.reset_low_ticks       <= i_data[9:0];
                CFG_PRESENCE_SAMPLE: r_cfg.presence_sample_ticks <= i_data[7:0];
                CFG_RESET_RECOVERY:  r_cfg.reset_recovery_ticks  <= i_data[9:0];
                CFG_SLOT:            r_cfg.slot_ticks            <= i_data[7:0];
                CFG_WRITE_LOW:       r_cfg.write_low_ticks       <= i_data[3:0];
                CFG_READ_LOW:        r_cfg.read_low_ticks        <= i_data[3:0];
                CFG_READ_SAMPLE:     r_cfg.read_sample_ticks     <= i_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/owtr_seq.sv
`timescale 1ns / 1ps

module owtr_seq
    import owtr_pkg::*;
#(
    parameter int COUNT_WIDTH = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    // Compare width covers both the largest register value and the counter cap
    localparam int CMP_W = (COUNT_WIDTH + 1 > CFG_DATA_W) ? COUNT_WIDTH + 1 : CFG_DATA_W;
    localparam logic [CMP_W-1:0] CAP = CMP_W'(1) << COUNT_WIDTH;

    typedef enum logic [10:0] {
        PH_IDLE        = 11'b000_0000_0001,
        PH_RST_LOW     = 11'b000_0000_0010,
        PH_RST_WAIT    = 11'b000_0000_0100,
        PH_RECOV_OK    = 11'b000_0000_1000,
        PH_RECOV_RETRY = 11'b000_0001_0000,
        PH_W_LOW       = 11'b000_0010_0000,
        PH_W_HOLD      = 11'b000_0100_0000,
        PH_W_REL       = 11'b000_1000_0000,
        PH_R_LOW       = 11'b001_0000_0000,
        PH_R_WAIT      = 11'b010_0000_0000,
        PH_R_SLOT      = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] shift;
    } t_op_start;

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_op, n_op;
    logic [2:0]             r_bit, n_bit;
    logic [7:0]             r_shift, n_shift;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [7:0]             r_low, n_low;
    logic [6:0]             r_temp, n_temp;

    logic [CFG_DATA_W-1:0]  lim_raw;
    logic [CMP_W-1:0]       lim_nz;
    logic [CMP_W-1:0]       lim;
    logic [CMP_W-1:0]       tick_inc;
    logic                   expired;
    logic                   end_bit;
    logic                   finish;
    logic                   begin_op;
    logic [2:0]             begin_idx;
    logic                   done;
    logic                   drive;
    t_op_start              op_start;

    // First phase and shift byte of each operation
    function automatic t_op_start start_of(input logic [2:0] op);
        t_op_start s;
        case (op)
            OP_RESET_FIRST, OP_RESET_SECOND: begin
                s.phase = PH_RST_LOW;
                s.shift = 8'h00;
            end
            OP_SKIP_FIRST, OP_SKIP_SECOND: begin
                s.phase = PH_W_LOW;
                s.shift = CMD_SKIP_ROM;
            end
            OP_CONVERT: begin
                s.phase = PH_W_LOW;
                s.shift = CMD_CONVERT;
            end
            OP_READ_CMD: begin
                s.phase = PH_W_LOW;
                s.shift = CMD_READ_SCRATCH;
            end
            default: begin
                s.phase = PH_R_LOW;
                s.shift = 8'h00;
            end
        endcase
        return s;
    endfunction

    // Select the duration of the current timed phase
    always_comb begin
        case (r_phase)
            PH_RST_LOW:                 lim_raw = i_cfg.reset_low_ticks;
            PH_RST_WAIT:                lim_raw = CFG_DATA_W'(i_cfg.presence_sample_ticks);
            PH_RECOV_OK, PH_RECOV_RETRY: lim_raw = i_cfg.reset_recovery_ticks;
            PH_W_LOW:                   lim_raw = CFG_DATA_W'(i_cfg.write_low_ticks);
            PH_W_HOLD, PH_R_SLOT:       lim_raw = CFG_DATA_W'(i_cfg.slot_ticks);
            PH_R_LOW:                   lim_raw = CFG_DATA_W'(i_cfg.read_low_ticks);
            PH_R_WAIT:                  lim_raw = CFG_DATA_W'(i_cfg.read_sample_ticks);
            default:                    lim_raw = '0;
        endcase
    end

    // Clamp the duration to one tick at least and to the counter range at most
    always_comb begin
        lim_nz   = (lim_raw == '0) ? CMP_W'(1) : CMP_W'(lim_raw);
        lim      = (lim_nz > CAP) ? CAP : lim_nz;
        tick_inc = CMP_W'(r_tick) + CMP_W'(1);
        expired  = (tick_inc >= lim);
    end

    // Advance the sequencer by one tick
    always_comb begin
        n_phase   = r_phase;
        n_op      = r_op;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_tick    = expired ? '0 : tick_inc[COUNT_WIDTH-1:0];
        n_low     = r_low;
        n_temp    = r_temp;
        end_bit   = 1'b0;
        finish    = 1'b0;
        begin_op  = 1'b0;
        begin_idx = r_op + 3'd1;
        done      = 1'b0;
        op_start  = start_of(begin_idx);

        case (r_phase)
            PH_IDLE: begin
                n_tick = r_tick;
                if (i_item.start_req) begin
                    begin_op  = 1'b1;
                    begin_idx = OP_RESET_FIRST;
                end
            end
            PH_RST_LOW: begin
                if (expired) n_phase = PH_RST_WAIT;
            end
            PH_RST_WAIT: begin
                if (expired) n_phase = i_item.line_level ? PH_RECOV_RETRY : PH_RECOV_OK;
            end
            PH_RECOV_OK: begin
                if (expired) finish = 1'b1;
            end
            PH_RECOV_RETRY: begin
                if (expired) n_phase = PH_RST_LOW;
            end
            PH_W_LOW: begin
                if (expired) n_phase = PH_W_HOLD;
            end
            PH_W_HOLD: begin
                if (expired) n_phase = PH_W_REL;
            end
            PH_W_REL: begin
                n_tick  = '0;
                end_bit = 1'b1;
            end
            PH_R_LOW: begin
                if (expired) n_phase = PH_R_WAIT;
            end
            PH_R_WAIT: begin
                if (expired) begin
                    n_shift = {i_item.line_level, r_shift[7:1]};
                    n_phase = PH_R_SLOT;
                end
            end
            PH_R_SLOT: begin
                if (expired) end_bit = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase

        // Close a bit slot: next bit or end of the operation
        if (end_bit) begin
            if (r_bit == 3'd7) begin
                finish = 1'b1;
            end else begin
                n_bit = r_bit + 3'd1;
                if (r_phase == PH_W_REL) begin
                    n_shift = {1'b0, r_shift[7:1]};
                    n_phase = PH_W_LOW;
                end else begin
                    n_phase = PH_R_LOW;
                end
            end
        end

        // Close an operation: latch the result or move to the next one
        if (finish) begin
            if (r_op == OP_READ_MSB) begin
                n_temp  = {r_shift[2:0], r_low[7:4]};
                n_phase = PH_IDLE;
                n_op    = OP_RESET_FIRST;
                n_bit   = 3'd0;
                n_tick  = '0;
                done    = 1'b1;
            end else begin
                if (r_op == OP_READ_LSB) n_low = r_shift;
                begin_op = 1'b1;
            end
        end

        // Open an operation
        if (begin_op) begin
            op_start = start_of(begin_idx);
            n_op     = begin_idx;
            n_tick   = '0;
            n_bit    = 3'd0;
            n_phase  = op_start.phase;
            n_shift  = op_start.shift;
        end
    end

    // Drive level for the next tick
    always_comb begin
        case (n_phase)
            PH_RST_LOW, PH_W_LOW, PH_R_LOW: drive = 1'b1;
            PH_W_HOLD:                      drive = ~n_shift[0];
            default:                        drive = 1'b0;
        endcase
    end

    always_comb begin
        o_result.drive_low   = drive;
        o_result.busy_res    = (n_phase != PH_IDLE);
        o_result.done_res    = done;
        o_result.temperature = n_temp;
    end

    // Hold state between ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_op    <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_tick  <= '0;
            r_low   <= '0;
            r_temp  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_tick  <= n_tick;
            r_low   <= n_low;
            r_temp  <= n_temp;
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import owtr_pkg::*;

    localparam int COUNT_W      = 10;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_TICKS = 150;
    localparam int HOLD_CYCLES  = 300;
    // Index past the last timing register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RECOV_OK, SEQ_RECOV_RETRY,
        SEQ_W_LOW, SEQ_W_HOLD, SEQ_W_REL, SEQ_R_LOW, SEQ_R_WAIT, SEQ_R_SLOT
    } t_seq_phase;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Sequencer mirror
    t_cfg        tcfg;
    t_seq_phase  ph;
    logic [2:0]  op_idx;
    logic [2:0]  bit_idx;
    logic [7:0]  shreg;
    logic [9:0]  tick_cnt;
    logic [7:0]  lsb_hold;
    logic [6:0]  temp_hold;

    t_out_item   tick_result_q[$];
    int          err_cnt      = 0;
    int          ticks_sent   = 0;
    int          ticks_done   = 0;
    int          busy_ticks   = 0;
    int          reads_cnt    = 0;
    int          settings_cnt = 0;
    int          cycle_cnt    = 0;
    bit          no_idle      = 1'b0;
    bit          hold_req     = 1'b0;
    int          hold_len     = 0;

    onewire_temperature_read_master_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Count one tick of a timed phase; return 1 when the phase has run out
    function automatic logic count_out(input int unsigned limit);
        int unsigned lim;
        lim = (limit == 0) ? 1 : limit;
        if (lim > (1 << COUNT_W)) lim = 1 << COUNT_W;
        if (tick_cnt + 1 >= lim) begin
            tick_cnt = '0;
            return 1'b1;
        end
        tick_cnt = tick_cnt + 1'b1;
        return 1'b0;
    endfunction

    function automatic void start_op();
        tick_cnt = '0;
        bit_idx  = '0;
        case (op_idx)
            OP_RESET_FIRST, OP_RESET_SECOND: ph = SEQ_RST_LOW;
            OP_SKIP_FIRST, OP_SKIP_SECOND: begin
                shreg = CMD_SKIP_ROM;
                ph    = SEQ_W_LOW;
            end
            OP_CONVERT: begin
                shreg = CMD_CONVERT;
                ph    = SEQ_W_LOW;
            end
            OP_READ_CMD: begin
                shreg = CMD_READ_SCRATCH;
                ph    = SEQ_W_LOW;
            end
            default: begin
                shreg = '0;
                ph    = SEQ_R_LOW;
            end
        endcase
    endfunction

    // Close the current bus operation; return 1 when the whole read is over
    function automatic logic close_op();
        logic [15:0] reading;
        if (op_idx == OP_READ_MSB) begin
            reading   = {shreg, lsb_hold};
            temp_hold = reading[10:4];
            ph        = SEQ_IDLE;
            op_idx    = '0;
            bit_idx   = '0;
            tick_cnt  = '0;
            return 1'b1;
        end
        if (op_idx == OP_READ_LSB) lsb_hold = shreg;
        op_idx = op_idx + 1'b1;
        start_op();
        return 1'b0;
    endfunction

    function automatic logic close_bit(input logic writing);
        if (bit_idx >= 3'd7) return close_op();
        bit_idx = bit_idx + 1'b1;
        if (writing) shreg = shreg >> 1;
        ph = writing ? SEQ_W_LOW : SEQ_R_LOW;
        return 1'b0;
    endfunction

    // Advance the sequencer mirror by one bus tick and form its output
    function automatic t_out_item sequence_tick(input logic start, input logic line);
        t_out_item res;
        logic      done;
        done = 1'b0;
        case (ph)
            SEQ_IDLE: begin
                if (start) begin
                    op_idx = OP_RESET_FIRST;
                    start_op();
                end
            end
            SEQ_RST_LOW: if (count_out(tcfg.reset_low_ticks)) ph = SEQ_RST_WAIT;
            SEQ_RST_WAIT: begin
                if (count_out(tcfg.presence_sample_ticks))
                    ph = line ? SEQ_RECOV_RETRY : SEQ_RECOV_OK;
            end
            SEQ_RECOV_OK: if (count_out(tcfg.reset_recovery_ticks)) done = close_op();
            SEQ_RECOV_RETRY: if (count_out(tcfg.reset_recovery_ticks)) ph = SEQ_RST_LOW;
            SEQ_W_LOW: if (count_out(tcfg.write_low_ticks)) ph = SEQ_W_HOLD;
            SEQ_W_HOLD: if (count_out(tcfg.slot_ticks)) ph = SEQ_W_REL;
            SEQ_W_REL: begin
                tick_cnt = '0;
                done     = close_bit(1'b1);
            end
            SEQ_R_LOW: if (count_out(tcfg.read_low_ticks)) ph = SEQ_R_WAIT;
            SEQ_R_WAIT: begin
                if (count_out(tcfg.read_sample_ticks)) begin
                    shreg = {line, shreg[7:1]};
                    ph    = SEQ_R_SLOT;
                end
            end
            SEQ_R_SLOT: if (count_out(tcfg.slot_ticks)) done = close_bit(1'b0);
            default: begin
                ph       = SEQ_IDLE;
                tick_cnt = '0;
            end
        endcase
        case (ph)
            SEQ_RST_LOW, SEQ_W_LOW, SEQ_R_LOW: res.drive_low = 1'b1;
            SEQ_W_HOLD: res.drive_low = ~shreg[0];
            default: res.drive_low = 1'b0;
        endcase
        res.busy_res    = (ph != SEQ_IDLE);
        res.done_res    = done;
        res.temperature = temp_hold;
        return res;
    endfunction

    // Check results, track register writes, predict each accepted tick
    always @(posedge i_clk) begin : monitor_p
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            tcfg.reset_low_ticks       = RST_RESET_LOW;
            tcfg.presence_sample_ticks = RST_PRESENCE_SAMPLE;
            tcfg.reset_recovery_ticks  = RST_RESET_RECOVERY;
            tcfg.slot_ticks            = RST_SLOT;
            tcfg.write_low_ticks       = RST_WRITE_LOW;
            tcfg.read_low_ticks        = RST_READ_LOW;
            tcfg.read_sample_ticks     = RST_READ_SAMPLE;
            ph        = SEQ_IDLE;
            op_idx    = '0;
            bit_idx   = '0;
            shreg     = '0;
            tick_cnt  = '0;
            lsb_hold  = '0;
            temp_hold = '0;
            tick_result_q.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = o_out_item;
                if (tick_result_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %p", $time, got);
                    err_cnt++;
                end else begin
                    want = tick_result_q.pop_front();
                    if (got.drive_low !== want.drive_low) begin
                        $display("%0t: drive_low expected %0b, got %0b",
                                 $time, want.drive_low, got.drive_low);
                        err_cnt++;
                    end
                    if (got.busy_res !== want.busy_res) begin
                        $display("%0t: busy_res expected %0b, got %0b",
                                 $time, want.busy_res, got.busy_res);
                        err_cnt++;
                    end
                    if (got.done_res !== want.done_res) begin
                        $display("%0t: done_res expected %0b, got %0b",
                                 $time, want.done_res, got.done_res);
                        err_cnt++;
                    end
                    if (got.temperature !== want.temperature) begin
                        $display("%0t: temperature expected %0d, got %0d",
                                 $time, want.temperature, got.temperature);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RESET_LOW:       tcfg.reset_low_ticks       = i_cfg_data[9:0];
                    CFG_PRESENCE_SAMPLE: tcfg.presence_sample_ticks = i_cfg_data[7:0];
                    CFG_RESET_RECOVERY:  tcfg.reset_recovery_ticks  = i_cfg_data[9:0];
                    CFG_SLOT:            tcfg.slot_ticks            = i_cfg_data[7:0];
                    CFG_WRITE_LOW:       tcfg.write_low_ticks       = i_cfg_data[3:0];
                    CFG_READ_LOW:        tcfg.read_low_ticks        = i_cfg_data[3:0];
                    CFG_READ_SAMPLE:     tcfg.read_sample_ticks     = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                tick_result_q.push_back(sequence_tick(i_in_item.start_req,
                                                      i_in_item.line_level));
                ticks_done++;
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, tick_result_q.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(12, 30);
    endfunction

    // Result side: random stall, or a long hold-off on request
    initial begin : stall_p
        int n;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = idle_len();
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Offer one tick item, wait for it to be taken, then maybe idle
    task automatic send_tick(input logic start, input logic line);
        t_in_item item;
        int       gap;
        item.start_req  = start;
        item.line_level = line;
        i_in_item  <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        ticks_sent++;
        wait (ticks_done == ticks_sent);
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and hold until every expected result has come
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tick_result_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_timing(input logic [9:0] rst_low, pres, recov, slot,
                              wlow, rlow, rsamp);
        drain_results();
        write_reg(CFG_RESET_LOW, rst_low);
        write_reg(CFG_PRESENCE_SAMPLE, pres);
        write_reg(CFG_RESET_RECOVERY, recov);
        write_reg(CFG_SLOT, slot);
        write_reg(CFG_WRITE_LOW, wlow);
        write_reg(CFG_READ_LOW, rlow);
        write_reg(CFG_READ_SAMPLE, rsamp);
        i_cfg_valid <= 1'b0;
        settings_cnt++;
    endtask

    // Run one temperature read, acting as the device on the bus.
    // The device answers presence only after answer_after ticks and
    // returns scratch LSB first; elsewhere the line is noise.
    // With slow_ticks above zero, switch to the shortest timing after that
    // many ticks so that long settings do not stretch the whole read.
    task automatic run_read(input logic [15:0] scratch, input int answer_after,
                            input int slow_ticks);
        int   k;
        logic line;
        k = 0;
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        while (ph != SEQ_IDLE) begin
            if (slow_ticks > 0 && k == slow_ticks)
                set_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
            case (ph)
                SEQ_RST_WAIT: line = !(k >= answer_after);
                SEQ_R_WAIT:   line = scratch[{op_idx == OP_READ_MSB, bit_idx}];
                default:      line = 1'($urandom_range(0, 1));
            endcase
            send_tick(1'($urandom_range(0, 1)), line);
            k++;
            busy_ticks++;
        end
        reads_cnt++;
    endtask

    task automatic test_idle_ticks();
        for (int i = 0; i < 8; i++) send_tick(1'b0, 1'(i));
    endtask

    // Run the start of the first bus reset on the timings left by reset
    task automatic test_reset_timing();
        run_read(16'h0550, 0, 520);
    endtask

    // Zero acts as one tick; check the temperature extremes and masking
    task automatic test_zero_timing();
        set_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        run_read(16'h07F0, 0, 0);
        run_read(16'hF80F, 0, 0);
    endtask

    // Keep resetting until the device finally answers
    task automatic test_lost_presence();
        set_timing(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
        run_read(16'($urandom), 40, 0);
    endtask

    // All-ones data lands as each narrow register's maximum; run through the
    // presence wait and into the first write slot on those values
    task automatic test_max_timing();
        drain_results();
        write_reg(CFG_UNUSED, 10'h155);
        set_timing(10'd2, 10'h3FF, 10'd2, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
        no_idle = 1'b1;
        run_read(16'($urandom), 0, 280);
        no_idle = 1'b0;
    endtask

    // Hold the result side off while ticks keep coming, then pause to drain
    task automatic test_backpressure();
        set_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        hold_len = HOLD_CYCLES;
        hold_req = 1'b1;
        run_read(16'($urandom), 0, 0);
        drain_results();
        run_read(16'($urandom), 0, 0);
    endtask

    task automatic test_random_reads();
        int  first;
        bit  wide;
        first = busy_ticks;
        while (busy_ticks - first < RANDOM_TICKS) begin
            wide = ($urandom_range(0, 5) == 0);
            set_timing(wide ? 10'($urandom_range(0, 30)) : 10'($urandom_range(0, 2)),
                       10'($urandom_range(0, wide ? 10 : 2)),
                       wide ? 10'($urandom_range(0, 30)) : 10'($urandom_range(0, 2)),
                       10'($urandom_range(0, wide ? 6 : 2)),
                       10'($urandom_range(0, wide ? 15 : 2)),
                       10'($urandom_range(0, wide ? 15 : 2)),
                       10'($urandom_range(0, wide ? 15 : 2)));
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 2)) begin
                repeat ($urandom_range(0, 4)) send_tick(1'b0, 1'($urandom_range(0, 1)));
                run_read(16'($urandom),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0, 0);
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_ticks();
        test_reset_timing();
        test_zero_timing();
        test_lost_presence();
        test_max_timing();
        test_backpressure();
        test_random_reads();

        // Let the last results through, then settle the verdict
        drain_results();
        repeat (4) @(posedge i_clk);
        if (tick_result_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, tick_result_q.size());
            err_cnt++;
        end
        $display("covered %0d temperature reads over %0d bus ticks, %0d timing settings",
                 reads_cnt, ticks_sent, settings_cnt);
        $display("timings ran from zero to all-ones, with lost presence and a long hold-off");
        if (err_cnt == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
